[hw/rtl/slotted_servo_pulse_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Servo sequencer assertion macros
// Shared concurrent assertion forms for the servo pulse sequencer.
// ----------------------------------------------------------------------------
`ifndef SLOTTED_SERVO_PULSE_SEQUENCER_DEFINES_SVH
`define SLOTTED_SERVO_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SSPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define SSPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ssps_pkg.sv]
// ----------------------------------------------------------------------------
// Servo sequencer package
// Types, register indexes and reset values shared by the sequencer modules.
// ----------------------------------------------------------------------------
package ssps_pkg;

   localparam int unsigned SERVO_COUNT_DEF = 16;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_MAP    = 2'd2;

   localparam logic [15:0] SLOT_PERIOD_RST = 16'd1513;
   localparam logic [15:0] MIN_PULSE_RST   = 16'd0;
   localparam logic [31:0] SLOT_MAP_RST    = 32'h0098_7531;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_SET   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [3:0]  servo_number;
      logic [14:0] pulse_value;
   } req_type;

   typedef struct packed {
      logic [15:0] pin_state;
      logic [15:0] next_duration;
      logic [7:0]  frame_count;
      logic        duty_valid;
      logic [1:0]  duty_channel;
      logic [15:0] duty_word;
   } res_type;

endpackage

[hw/rtl/ssps_in_stage.sv]
// ----------------------------------------------------------------------------
// Servo sequencer input register
// Holds one accepted request until the core can process it.
// ----------------------------------------------------------------------------
module ssps_in_stage
   import ssps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   input  logic    down_ready,
   output logic    fire,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign fire     = valid_ff && down_ready;
   assign in_ready = !valid_ff || down_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !down_ready);
   assign item     = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

[hw/rtl/ssps_core.sv]
// ----------------------------------------------------------------------------
// Servo sequencer core
// Configuration registers, servo time buffers and slot state; computes the
// result of one request combinationally and updates state on fire.
// ----------------------------------------------------------------------------
module ssps_core
   import ssps_pkg::*;
#(
   parameter int unsigned SERVO_COUNT = SERVO_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  fire,
   input  req_type               item,
   output res_type               res
);

   localparam int unsigned IDX_W = $clog2(SERVO_COUNT);

   logic [15:0] slot_period_ff;
   logic [15:0] min_pulse_ff;
   logic [31:0] slot_map_ff;

   logic [15:0] active_time_ff  [SERVO_COUNT];
   logic [15:0] pending_time_ff [SERVO_COUNT];
   logic        pending_flag_ff [SERVO_COUNT];
   logic [2:0]  slot_index_ff;
   logic        pulse_high_ff;
   logic [7:0]  frame_counter_ff;
   logic [15:0] pin_levels_ff;

   logic [2:0]  slot_index_in;
   logic        pulse_high_in;
   logic [7:0]  frame_counter_in;
   logic [15:0] pin_levels_in;

   // set path
   logic [16:0]      sum;
   logic [15:0]      set_time;
   logic             set_ok;
   logic [IDX_W-1:0] set_idx;
   logic             duty_servo;

   // event path
   logic [3:0]       map_nib;
   logic             slot_used;
   logic [IDX_W-1:0] slot_idx;
   logic             load;
   logic [15:0]      tm;
   logic [15:0]      low_time;
   logic             advance;

   always_comb begin
      sum        = {1'b0, 1'b0, item.pulse_value} + {1'b0, min_pulse_ff};
      set_time   = (item.pulse_value == 15'd0) ? 16'd0 :
                   (sum[16] ? 16'hFFFF : sum[15:0]);
      set_ok     = ({1'b0, item.servo_number} < 5'(SERVO_COUNT));
      set_idx    = item.servo_number[IDX_W-1:0];
      duty_servo = !item.servo_number[3] && !item.servo_number[0];

      map_nib   = 4'(slot_map_ff >> {slot_index_ff, 2'b00});
      slot_used = (map_nib != 4'd0) && ({1'b0, map_nib} < 5'(SERVO_COUNT));
      slot_idx  = map_nib[IDX_W-1:0];
      load      = slot_used && !pulse_high_ff && pending_flag_ff[slot_idx];
      tm        = !slot_used ? 16'd0 :
                  (load ? pending_time_ff[slot_idx] : active_time_ff[slot_idx]);
      low_time  = (slot_period_ff > tm) ? (slot_period_ff - tm) : 16'd0;

      slot_index_in    = slot_index_ff;
      pulse_high_in    = pulse_high_ff;
      frame_counter_in = frame_counter_ff;
      pin_levels_in    = pin_levels_ff;
      advance          = 1'b0;

      res.next_duration = 16'd0;
      res.duty_valid    = 1'b0;
      res.duty_channel  = 2'd0;
      res.duty_word     = 16'd0;

      if (item.operation == OP_SET) begin
         if (duty_servo) begin
            res.duty_valid   = 1'b1;
            res.duty_channel = item.servo_number[2:1];
            res.duty_word    = set_time[15] ? 16'hFFFF : {set_time[14:0], 1'b0};
         end
      end else begin
         if (tm != 16'd0) begin
            pulse_high_in = !pulse_high_ff;
            pin_levels_in = pulse_high_ff ? 16'd0 : (16'd1 << map_nib);
         end else begin
            // empty slot or zero time: any running pulse ends here
            pulse_high_in = 1'b0;
            pin_levels_in = pulse_high_ff ? 16'd0 : pin_levels_ff;
         end
         if (pulse_high_in) begin
            res.next_duration = tm;
         end else begin
            res.next_duration = low_time;
            advance           = 1'b1;
         end
      end

      if (advance) begin
         slot_index_in = slot_index_ff + 3'd1;
         if (slot_index_ff == 3'd7) begin
            frame_counter_in = frame_counter_ff + 8'd1;
         end
      end

      res.pin_state   = pin_levels_in;
      res.frame_count = frame_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_period_ff   <= SLOT_PERIOD_RST;
         min_pulse_ff     <= MIN_PULSE_RST;
         slot_map_ff      <= SLOT_MAP_RST;
         slot_index_ff    <= 3'd0;
         pulse_high_ff    <= 1'b0;
         frame_counter_ff <= 8'd0;
         pin_levels_ff    <= 16'd0;
         for (int i = 0; i < SERVO_COUNT; i++) begin
            active_time_ff[i]  <= 16'd0;
            pending_time_ff[i] <= 16'd0;
            pending_flag_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLOT_PERIOD: slot_period_ff <= csr_wdata[15:0];
               CSR_MIN_PULSE:   min_pulse_ff   <= csr_wdata[15:0];
               CSR_SLOT_MAP:    slot_map_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (fire) begin
            slot_index_ff    <= slot_index_in;
            pulse_high_ff    <= pulse_high_in;
            frame_counter_ff <= frame_counter_in;
            pin_levels_ff    <= pin_levels_in;
            if (item.operation == OP_SET) begin
               if (set_ok) begin
                  pending_time_ff[set_idx] <= set_time;
                  pending_flag_ff[set_idx] <= 1'b1;
               end
            end else if (load) begin
               active_time_ff[slot_idx]  <= pending_time_ff[slot_idx];
               pending_flag_ff[slot_idx] <= 1'b0;
            end
         end
      end
   end

endmodule

[hw/rtl/ssps_out_stage.sv]
// ----------------------------------------------------------------------------
// Servo sequencer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ssps_out_stage
   import ssps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  res_type res_in,
   output logic    up_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output res_type res_out
);

   logic    valid_ff;
   logic    valid_in;
   res_type res_ff;

   assign up_ready  = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign res_out   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= res_in;
      end
   end

endmodule

[hw/rtl/slotted_servo_pulse_sequencer.sv]
// ----------------------------------------------------------------------------
// Slotted servo pulse sequencer
// Time-multiplexed servo pulse generator with double-buffered servo times.
// ----------------------------------------------------------------------------
// A request is held in the input register until the result register can
// accept its result; the core works out that result in a single pass, and it
// is captured in the result register when the request fires, then offered
// on rsp until taken. A new request is taken every cycle while the result side
// keeps up. The request kind (tuser) selects a timer expiry event, which steps
// the slot pulse and reports the next timer load, or a servo time write, which
// fills the pending buffer and may give a PWM duty word. Registers are written
// through csr_*; the user must write them only while the block is idle, which
// the block itself does not enforce.
`include "slotted_servo_pulse_sequencer_defines.svh"

module slotted_servo_pulse_sequencer
   import ssps_pkg::*;
#(
   parameter int unsigned SERVO_COUNT = SERVO_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // servo_number[3:0], pulse_value[18:4]
   input  logic                  req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,  // pin_state[15:0], next_duration[31:16],
                                             // frame_count[39:32], duty_channel[41:40],
                                             // duty_word[57:42]
   output logic                  rsp_tuser,  // duty_valid
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   req_type in_item;
   req_type item;
   res_type res;
   res_type res_out;
   logic    fire;
   logic    up_ready;

   assign in_item.operation    = req_tuser;
   assign in_item.servo_number = req_tdata[3:0];
   assign in_item.pulse_value  = req_tdata[18:4];

   ssps_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .down_ready (up_ready),
      .fire       (fire),
      .item       (item)
   );

   ssps_core #(
      .SERVO_COUNT (SERVO_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .res       (res)
   );

   ssps_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .res_in    (res),
      .up_ready  (up_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .res_out   (res_out)
   );

   assign rsp_tdata = {6'd0, res_out.duty_word, res_out.duty_channel,
                       res_out.frame_count, res_out.next_duration, res_out.pin_state};
   assign rsp_tuser = res_out.duty_valid;

   `SSPS_ASSERT_NOW(a_one_pin, clock, reset, rsp_tvalid, $onehot0(res_out.pin_state),
      "more than one servo pin high")
   `SSPS_ASSERT_NOW(a_duty_no_timer, clock, reset, rsp_tvalid && rsp_tuser,
      res_out.next_duration == 16'd0, "duty result carries a timer load")
   `SSPS_ASSERT_NOW(a_duty_quiet, clock, reset, rsp_tvalid && !rsp_tuser,
      res_out.duty_word == 16'd0 && res_out.duty_channel == 2'd0,
      "duty fields set without a duty write")
   `SSPS_ASSERT_NEXT(a_result_follows, clock, reset, fire, rsp_tvalid,
      "processed request left no result")

endmodule
